// ===== rtl/cholesky_3x3_decompose_macros.svh =====
// Assertion macros for the 3x3 Cholesky block checker.
`ifndef CHOLESKY_3X3_DECOMPOSE_MACROS_SVH
`define CHOLESKY_3X3_DECOMPOSE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHOL3_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define CHOL3_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/chol3_pkg.sv =====
// Shared constants for the 3x3 Cholesky block.
`timescale 1ns / 1ps
package chol3_pkg;
   // Port width of every matrix and factor entry.
   localparam int IO_W = 64;
   // Width and reset value of the negative pivot tolerance register.
   localparam int TOL_W = 16;
   localparam logic [TOL_W-1:0] TOL_RESET = 16'd168;
endpackage

// ===== rtl/cholesky_3x3_decompose.sv =====
// Throughput: one matrix per cycle; a stalled result holds the whole pipeline in place.
// Reset clears all valid bits and loads the tolerance register with 168; payload is not reset.
// Top level of the pipelined 3x3 Cholesky decomposition.
`timescale 1ns / 1ps
module cholesky_3x3_decompose
   import chol3_pkg::*;
#(
   parameter int DATA_WIDTH = 64,
   parameter int FRAC_BITS  = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [TOL_W-1:0]       csr_wr_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [IO_W-1:0] req_a_00,
   input  logic signed [IO_W-1:0] req_a_10,
   input  logic signed [IO_W-1:0] req_a_11,
   input  logic signed [IO_W-1:0] req_a_20,
   input  logic signed [IO_W-1:0] req_a_21,
   input  logic signed [IO_W-1:0] req_a_22,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [IO_W-1:0] rsp_u_00,
   output logic signed [IO_W-1:0] rsp_u_01,
   output logic signed [IO_W-1:0] rsp_u_02,
   output logic signed [IO_W-1:0] rsp_u_11,
   output logic signed [IO_W-1:0] rsp_u_12,
   output logic signed [IO_W-1:0] rsp_u_22,
   output logic                   rsp_success
);
   localparam int W       = DATA_WIDTH;
   localparam int PW      = 2 * DATA_WIDTH;
   localparam int HL      = DATA_WIDTH / 2;
   localparam int HH      = DATA_WIDTH - HL;
   localparam int MUL_LAT = 4;
   localparam int SIDE1_W = 1 + 3 * DATA_WIDTH;
   localparam int SIDEM_W = 1 + 6 * DATA_WIDTH;
   localparam int SIDE5_W = 1 + 5 * DATA_WIDTH;

   typedef logic signed [DATA_WIDTH-1:0] fx_type;

   localparam fx_type MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam fx_type MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic signed [IO_W-1:0] MAXV_IO = IO_W'(MAXV);
   localparam logic signed [IO_W-1:0] MINV_IO = IO_W'(MINV);

   // ---------------------------------------------------------------- helpers
   function automatic fx_type clamp_in(logic signed [IO_W-1:0] x);
      fx_type r;
      if (x > MAXV_IO) begin
         r = MAXV;
      end else if (x < MINV_IO) begin
         r = MINV;
      end else begin
         r = fx_type'(x[W-1:0]);
      end
      return r;
   endfunction

   function automatic fx_type sat_sub(fx_type a, fx_type b);
      logic signed [DATA_WIDTH:0] d;
      d = (W+1)'(a) - (W+1)'(b);
      return (d[W] != d[W-1]) ? (d[W] ? MINV : MAXV) : fx_type'(d[W-1:0]);
   endfunction

   function automatic fx_type sat_add(fx_type a, fx_type b);
      logic signed [DATA_WIDTH:0] d;
      d = (W+1)'(a) + (W+1)'(b);
      return (d[W] != d[W-1]) ? (d[W] ? MINV : MAXV) : fx_type'(d[W-1:0]);
   endfunction

   // A negative pivot fails unless its magnitude is below the tolerance
   function automatic logic piv_fail(fx_type p, logic [TOL_W-1:0] tol);
      logic [DATA_WIDTH-1:0] mag;
      mag = W'(-p);
      return p[W-1] && !(mag < W'(tol));
   endfunction

   function automatic fx_type piv_val(fx_type p);
      return p[W-1] ? fx_type'(-p) : p;
   endfunction

   // ---------------------------------------------------------------- control
   logic             advance;
   logic [TOL_W-1:0] tol_ff;
   logic             rsp_valid_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // Load the tolerance register on a CSR write
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   // ---------------------------------------------------------------- stage 0: input
   logic   v0_ff;
   fx_type a00_0_ff, a10_0_ff, a11_0_ff, a20_0_ff, a21_0_ff, a22_0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (advance) begin
         v0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a00_0_ff <= clamp_in(req_a_00);
         a10_0_ff <= clamp_in(req_a_10);
         a11_0_ff <= clamp_in(req_a_11);
         a20_0_ff <= clamp_in(req_a_20);
         a21_0_ff <= clamp_in(req_a_21);
         a22_0_ff <= clamp_in(req_a_22);
      end
   end

   // ---------------------------------------------------------------- stage 1: first pivot
   logic   v1_ff, fail1_ff;
   fx_type p00_1_ff, a10_1_ff, a11_1_ff, a20_1_ff, a21_1_ff, a22_1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fail1_ff <= piv_fail(a00_0_ff, tol_ff);
         p00_1_ff <= piv_val(a00_0_ff);
         a10_1_ff <= a10_0_ff;
         a11_1_ff <= a11_0_ff;
         a20_1_ff <= a20_0_ff;
         a21_1_ff <= a21_0_ff;
         a22_1_ff <= a22_0_ff;
      end
   end

   // ---------------------------------------------------------------- root L00
   logic               v2, fail2, fail2b;
   logic [W-1:0]       l00_root;
   logic [SIDE5_W-1:0] side2;
   fx_type             l00_2, a10_2, a11_2, a20_2, a21_2, a22_2;

   chol3_sqrt #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE5_W)) u_sqrt_a (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (v1_ff),
      .in_rad    (p00_1_ff),
      .in_side   ({fail1_ff, a10_1_ff, a11_1_ff, a20_1_ff, a21_1_ff, a22_1_ff}),
      .out_valid (v2),
      .out_root  (l00_root),
      .out_side  (side2)
   );

   assign {fail2, a10_2, a11_2, a20_2, a21_2, a22_2} = side2;
   assign l00_2  = fx_type'(l00_root);
   assign fail2b = fail2 || (l00_2 == '0);

   // ---------------------------------------------------------------- L10, L20
   logic               v3a, v3b, v3, fail3;
   logic [SIDE1_W-1:0] side3a;
   logic [W-1:0]       side3b;
   fx_type             l10_3, l20_3, l00_3, a11_3, a21_3, a22_3;

   chol3_div #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE1_W)) u_div_l10 (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (v2),
      .in_num    (a10_2),
      .in_den    (l00_root),
      .in_side   ({fail2b, l00_2, a11_2, a21_2}),
      .out_valid (v3a),
      .out_quot  (l10_3),
      .out_side  (side3a)
   );

   chol3_div #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS), .SIDE_W(W)) u_div_l20 (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (v2),
      .in_num    (a20_2),
      .in_den    (l00_root),
      .in_side   (a22_2),
      .out_valid (v3b),
      .out_quot  (l20_3),
      .out_side  (side3b)
   );

   assign {fail3, l00_3, a11_3, a21_3} = side3a;
   assign a22_3 = fx_type'(side3b);
   assign v3    = v3a && v3b;

   // ---------------------------------------------------------------- multiplier lanes
   fx_type mul_a [4];
   fx_type mul_b [4];
   fx_type mul_p [4];

   assign mul_a[0] = l10_3;
   assign mul_b[0] = l10_3;
   assign mul_a[1] = l20_3;
   assign mul_b[1] = l10_3;

   for (genvar k = 0; k < 4; k++) begin : g_mul
      logic [W-1:0]       ma_ff, mb_ff;
      logic               neg1_ff, neg2_ff, neg3_ff;
      logic [2*HL-1:0]    pp_ll_ff;
      logic [HL+HH-1:0]   pp_lh_ff, pp_hl_ff;
      logic [2*HH-1:0]    pp_hh_ff;
      logic [PW-1:0]      sum_ff;
      logic [PW-1:0]      sh;
      fx_type             res_ff;

      assign sh = sum_ff >> FRAC_BITS;

      // Split magnitudes, form partial products, sum, then scale and saturate
      always_ff @(posedge clock) begin
         if (advance) begin
            ma_ff    <= mul_a[k][W-1] ? W'(-mul_a[k]) : W'(mul_a[k]);
            mb_ff    <= mul_b[k][W-1] ? W'(-mul_b[k]) : W'(mul_b[k]);
            neg1_ff  <= mul_a[k][W-1] ^ mul_b[k][W-1];
            pp_ll_ff <= ma_ff[HL-1:0] * mb_ff[HL-1:0];
            pp_lh_ff <= ma_ff[HL-1:0] * mb_ff[W-1:HL];
            pp_hl_ff <= ma_ff[W-1:HL] * mb_ff[HL-1:0];
            pp_hh_ff <= ma_ff[W-1:HL] * mb_ff[W-1:HL];
            neg2_ff  <= neg1_ff;
            sum_ff   <= PW'(pp_ll_ff) + (PW'(pp_lh_ff) << HL) + (PW'(pp_hl_ff) << HL)
                        + (PW'(pp_hh_ff) << (2 * HL));
            neg3_ff  <= neg2_ff;
            if (sh > PW'(MAXV)) begin
               res_ff <= neg3_ff ? MINV : MAXV;
            end else if (neg3_ff) begin
               res_ff <= fx_type'(-sh[W-1:0]);
            end else begin
               res_ff <= fx_type'(sh[W-1:0]);
            end
         end
      end

      assign mul_p[k] = res_ff;
   end

   // Carry the first product pair's side-band alongside the lanes
   logic [SIDEM_W-1:0] sm1_ff [MUL_LAT];
   logic               vm1_ff [MUL_LAT];

   for (genvar s = 0; s < MUL_LAT; s++) begin : g_sm1
      always_ff @(posedge clock) begin
         if (advance) begin
            sm1_ff[s] <= (s == 0) ? {fail3, l00_3, l10_3, l20_3, a11_3, a21_3, a22_3}
                                  : sm1_ff[(s == 0) ? 0 : s-1];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vm1_ff[s] <= 1'b0;
         end else if (advance) begin
            vm1_ff[s] <= (s == 0) ? v3 : vm1_ff[(s == 0) ? 0 : s-1];
         end
      end
   end

   logic   fail_m1;
   fx_type l00_m1, l10_m1, l20_m1, a11_m1, a21_m1, a22_m1;
   assign {fail_m1, l00_m1, l10_m1, l20_m1, a11_m1, a21_m1, a22_m1} = sm1_ff[MUL_LAT-1];

   // ---------------------------------------------------------------- stage 4: differences
   logic   v4_ff, fail4_ff;
   fx_type t11_4_ff, d21_4_ff, l00_4_ff, l10_4_ff, l20_4_ff, a22_4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (advance) begin
         v4_ff <= vm1_ff[MUL_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fail4_ff <= fail_m1;
         t11_4_ff <= sat_sub(a11_m1, mul_p[0]);
         d21_4_ff <= sat_sub(a21_m1, mul_p[1]);
         l00_4_ff <= l00_m1;
         l10_4_ff <= l10_m1;
         l20_4_ff <= l20_m1;
         a22_4_ff <= a22_m1;
      end
   end

   // ---------------------------------------------------------------- stage 5: second pivot
   logic   v5_ff, fail5_ff;
   fx_type p11_5_ff, d21_5_ff, l00_5_ff, l10_5_ff, l20_5_ff, a22_5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (advance) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fail5_ff <= fail4_ff || piv_fail(t11_4_ff, tol_ff);
         p11_5_ff <= piv_val(t11_4_ff);
         d21_5_ff <= d21_4_ff;
         l00_5_ff <= l00_4_ff;
         l10_5_ff <= l10_4_ff;
         l20_5_ff <= l20_4_ff;
         a22_5_ff <= a22_4_ff;
      end
   end

   // ---------------------------------------------------------------- root L11
   logic               v6, fail6, fail6b;
   logic [W-1:0]       l11_root;
   logic [SIDE5_W-1:0] side6;
   fx_type             l11_6, d21_6, l00_6, l10_6, l20_6, a22_6;

   chol3_sqrt #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE5_W)) u_sqrt_b (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (v5_ff),
      .in_rad    (p11_5_ff),
      .in_side   ({fail5_ff, d21_5_ff, l00_5_ff, l10_5_ff, l20_5_ff, a22_5_ff}),
      .out_valid (v6),
      .out_root  (l11_root),
      .out_side  (side6)
   );

   assign {fail6, d21_6, l00_6, l10_6, l20_6, a22_6} = side6;
   assign l11_6  = fx_type'(l11_root);
   assign fail6b = fail6 || (l11_6 == '0);

   // ---------------------------------------------------------------- L21
   logic               v7, fail7;
   logic [SIDE5_W-1:0] side7;
   fx_type             l21_7, l00_7, l10_7, l20_7, l11_7, a22_7;

   chol3_div #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE5_W)) u_div_l21 (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (v6),
      .in_num    (d21_6),
      .in_den    (l11_root),
      .in_side   ({fail6b, l00_6, l10_6, l20_6, l11_6, a22_6}),
      .out_valid (v7),
      .out_quot  (l21_7),
      .out_side  (side7)
   );

   assign {fail7, l00_7, l10_7, l20_7, l11_7, a22_7} = side7;

   assign mul_a[2] = l20_7;
   assign mul_b[2] = l20_7;
   assign mul_a[3] = l21_7;
   assign mul_b[3] = l21_7;

   // Carry the second product pair's side-band alongside the lanes
   logic [SIDEM_W-1:0] sm2_ff [MUL_LAT];
   logic               vm2_ff [MUL_LAT];

   for (genvar s = 0; s < MUL_LAT; s++) begin : g_sm2
      always_ff @(posedge clock) begin
         if (advance) begin
            sm2_ff[s] <= (s == 0) ? {fail7, l00_7, l10_7, l20_7, l11_7, l21_7, a22_7}
                                  : sm2_ff[(s == 0) ? 0 : s-1];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vm2_ff[s] <= 1'b0;
         end else if (advance) begin
            vm2_ff[s] <= (s == 0) ? v7 : vm2_ff[(s == 0) ? 0 : s-1];
         end
      end
   end

   logic   fail_m2;
   fx_type l00_m2, l10_m2, l20_m2, l11_m2, l21_m2, a22_m2;
   assign {fail_m2, l00_m2, l10_m2, l20_m2, l11_m2, l21_m2, a22_m2} = sm2_ff[MUL_LAT-1];

   // ---------------------------------------------------------------- stage 8: sum of squares
   logic   v8_ff, fail8_ff;
   fx_type s_8_ff, l00_8_ff, l10_8_ff, l20_8_ff, l11_8_ff, l21_8_ff, a22_8_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else if (advance) begin
         v8_ff <= vm2_ff[MUL_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fail8_ff <= fail_m2;
         s_8_ff   <= sat_add(mul_p[2], mul_p[3]);
         l00_8_ff <= l00_m2;
         l10_8_ff <= l10_m2;
         l20_8_ff <= l20_m2;
         l11_8_ff <= l11_m2;
         l21_8_ff <= l21_m2;
         a22_8_ff <= a22_m2;
      end
   end

   // ---------------------------------------------------------------- stage 9: last difference
   logic   v9_ff, fail9_ff;
   fx_type t22_9_ff, l00_9_ff, l10_9_ff, l20_9_ff, l11_9_ff, l21_9_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff <= 1'b0;
      end else if (advance) begin
         v9_ff <= v8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fail9_ff <= fail8_ff;
         t22_9_ff <= sat_sub(a22_8_ff, s_8_ff);
         l00_9_ff <= l00_8_ff;
         l10_9_ff <= l10_8_ff;
         l20_9_ff <= l20_8_ff;
         l11_9_ff <= l11_8_ff;
         l21_9_ff <= l21_8_ff;
      end
   end

   // ---------------------------------------------------------------- stage 10: third pivot
   logic   v10_ff, fail10_ff;
   fx_type p22_10_ff, l00_10_ff, l10_10_ff, l20_10_ff, l11_10_ff, l21_10_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v10_ff <= 1'b0;
      end else if (advance) begin
         v10_ff <= v9_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fail10_ff <= fail9_ff || piv_fail(t22_9_ff, tol_ff);
         p22_10_ff <= piv_val(t22_9_ff);
         l00_10_ff <= l00_9_ff;
         l10_10_ff <= l10_9_ff;
         l20_10_ff <= l20_9_ff;
         l11_10_ff <= l11_9_ff;
         l21_10_ff <= l21_9_ff;
      end
   end

   // ---------------------------------------------------------------- root L22
   logic               v11, fail11, ok11;
   logic [W-1:0]       l22_root;
   logic [SIDE5_W-1:0] side11;
   fx_type             l22_11, l00_11, l10_11, l20_11, l11_11, l21_11;

   chol3_sqrt #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE5_W)) u_sqrt_c (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (v10_ff),
      .in_rad    (p22_10_ff),
      .in_side   ({fail10_ff, l00_10_ff, l10_10_ff, l20_10_ff, l11_10_ff, l21_10_ff}),
      .out_valid (v11),
      .out_root  (l22_root),
      .out_side  (side11)
   );

   assign {fail11, l00_11, l10_11, l20_11, l11_11, l21_11} = side11;
   assign l22_11 = fx_type'(l22_root);
   assign ok11   = !fail11 && (l22_11 != '0);

   // ---------------------------------------------------------------- output register
   fx_type u00_ff, u01_ff, u02_ff, u11_ff, u12_ff, u22_ff;
   logic   success_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= v11;
      end
   end

   // Drop every factor entry to zero on a failed item
   always_ff @(posedge clock) begin
      if (advance) begin
         success_ff <= ok11;
         u00_ff     <= ok11 ? l00_11 : '0;
         u01_ff     <= ok11 ? l10_11 : '0;
         u02_ff     <= ok11 ? l20_11 : '0;
         u11_ff     <= ok11 ? l11_11 : '0;
         u12_ff     <= ok11 ? l21_11 : '0;
         u22_ff     <= ok11 ? l22_11 : '0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_success = success_ff;
   assign rsp_u_00    = IO_W'(u00_ff);
   assign rsp_u_01    = IO_W'(u01_ff);
   assign rsp_u_02    = IO_W'(u02_ff);
   assign rsp_u_11    = IO_W'(u11_ff);
   assign rsp_u_12    = IO_W'(u12_ff);
   assign rsp_u_22    = IO_W'(u22_ff);
endmodule

// ===== rtl/chol3_sqrt.sv =====
// Pipelined fixed-point square root, one root bit per stage, with side-band.
`timescale 1ns / 1ps
module chol3_sqrt
   import chol3_pkg::*;
#(
   parameter int DATA_WIDTH = 64,
   parameter int FRAC_BITS  = 24,
   parameter int SIDE_W     = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic [DATA_WIDTH-1:0] in_rad,
   input  logic [SIDE_W-1:0]     in_side,
   output logic                  out_valid,
   output logic [DATA_WIDTH-1:0] out_root,
   output logic [SIDE_W-1:0]     out_side
);
   localparam int XB = DATA_WIDTH - 1 + FRAC_BITS;
   localparam int RB = (XB + 1) / 2;
   localparam int XW = 2 * RB;
   localparam int RW = RB + 3;
   localparam int CW = (RB > DATA_WIDTH) ? RB : DATA_WIDTH;
   localparam logic [CW-1:0] MAXV_C = CW'({1'b0, {(DATA_WIDTH-1){1'b1}}});

   logic [RW-1:0]     rem_ff  [RB];
   logic [RB-1:0]     root_ff [RB];
   logic [XW-1:0]     xr_ff   [RB];
   logic [SIDE_W-1:0] side_ff [RB];
   logic              vld_ff  [RB];

   logic [DATA_WIDTH-1:0] out_root_ff;
   logic [SIDE_W-1:0]     out_side_ff;
   logic                  out_valid_ff;
   logic [CW-1:0]         root_ext;

   for (genvar k = 0; k < RB; k++) begin : g_step
      logic [RW-1:0]     rem_i;
      logic [RB-1:0]     root_i;
      logic [XW-1:0]     xr_i;
      logic [SIDE_W-1:0] side_i;
      logic              vld_i;
      logic [RW-1:0]     rem_sh;
      logic [RW-1:0]     trial;
      logic              ge;

      if (k == 0) begin : g_first
         assign rem_i  = '0;
         assign root_i = '0;
         assign xr_i   = XW'(in_rad) << FRAC_BITS;
         assign side_i = in_side;
         assign vld_i  = in_valid;
      end else begin : g_next
         assign rem_i  = rem_ff[k-1];
         assign root_i = root_ff[k-1];
         assign xr_i   = xr_ff[k-1];
         assign side_i = side_ff[k-1];
         assign vld_i  = vld_ff[k-1];
      end

      // Bring down two radicand bits and try the next root bit
      assign rem_sh = {rem_i[RW-3:0], xr_i[XW-1:XW-2]};
      assign trial  = RW'({root_i, 2'b01});
      assign ge     = rem_sh >= trial;

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= ge ? rem_sh - trial : rem_sh;
            root_ff[k] <= {root_i[RB-2:0], ge};
            xr_ff[k]   <= xr_i << 2;
            side_ff[k] <= side_i;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (advance) begin
            vld_ff[k] <= vld_i;
         end
      end
   end

   // Clamp the root to the positive range
   assign root_ext = CW'(root_ff[RB-1]);

   always_ff @(posedge clock) begin
      if (advance) begin
         out_root_ff <= (root_ext > MAXV_C) ? DATA_WIDTH'(MAXV_C) : root_ext[DATA_WIDTH-1:0];
         out_side_ff <= side_ff[RB-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= vld_ff[RB-1];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_root  = out_root_ff;
   assign out_side  = out_side_ff;
endmodule

// ===== rtl/chol3_div.sv =====
// Pipelined fixed-point signed division, one quotient bit per stage, with side-band.
`timescale 1ns / 1ps
module chol3_div
   import chol3_pkg::*;
#(
   parameter int DATA_WIDTH = 64,
   parameter int FRAC_BITS  = 24,
   parameter int SIDE_W     = 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         in_valid,
   input  logic signed [DATA_WIDTH-1:0] in_num,
   input  logic [DATA_WIDTH-1:0]        in_den,
   input  logic [SIDE_W-1:0]            in_side,
   output logic                         out_valid,
   output logic signed [DATA_WIDTH-1:0] out_quot,
   output logic [SIDE_W-1:0]            out_side
);
   localparam int W  = DATA_WIDTH;
   localparam int NB = DATA_WIDTH + FRAC_BITS;
   localparam logic [NB-1:0] MAXV_Q = NB'({1'b0, {(W-1){1'b1}}});
   localparam logic [W-1:0]  MAXV   = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0]  MINV   = {1'b1, {(W-1){1'b0}}};

   logic [W-1:0]      rem_ff  [NB];
   logic [NB-1:0]     q_ff    [NB];
   logic [NB-1:0]     xr_ff   [NB];
   logic [W-1:0]      den_ff  [NB];
   logic              neg_ff  [NB];
   logic [SIDE_W-1:0] side_ff [NB];
   logic              vld_ff  [NB];

   logic [W-1:0]          mag;
   logic [W-1:0]          out_quot_ff;
   logic [SIDE_W-1:0]     out_side_ff;
   logic                  out_valid_ff;
   logic [NB-1:0]         q_last;

   assign mag = in_num[W-1] ? W'(-in_num) : W'(in_num);

   for (genvar k = 0; k < NB; k++) begin : g_step
      logic [W-1:0]      rem_i;
      logic [NB-1:0]     q_i;
      logic [NB-1:0]     xr_i;
      logic [W-1:0]      den_i;
      logic              neg_i;
      logic [SIDE_W-1:0] side_i;
      logic              vld_i;
      logic [W:0]        rs;
      logic [W:0]        diff;
      logic              ge;

      if (k == 0) begin : g_first
         assign rem_i  = '0;
         assign q_i    = '0;
         assign xr_i   = NB'(mag) << FRAC_BITS;
         assign den_i  = in_den;
         assign neg_i  = in_num[W-1];
         assign side_i = in_side;
         assign vld_i  = in_valid;
      end else begin : g_next
         assign rem_i  = rem_ff[k-1];
         assign q_i    = q_ff[k-1];
         assign xr_i   = xr_ff[k-1];
         assign den_i  = den_ff[k-1];
         assign neg_i  = neg_ff[k-1];
         assign side_i = side_ff[k-1];
         assign vld_i  = vld_ff[k-1];
      end

      // Shift in the next dividend bit and subtract when it fits
      assign rs   = {rem_i, xr_i[NB-1]};
      assign diff = rs - {1'b0, den_i};
      assign ge   = rs >= {1'b0, den_i};

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= ge ? diff[W-1:0] : rs[W-1:0];
            q_ff[k]    <= {q_i[NB-2:0], ge};
            xr_ff[k]   <= xr_i << 1;
            den_ff[k]  <= den_i;
            neg_ff[k]  <= neg_i;
            side_ff[k] <= side_i;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (advance) begin
            vld_ff[k] <= vld_i;
         end
      end
   end

   assign q_last = q_ff[NB-1];

   // Apply sign and saturate the quotient magnitude
   always_ff @(posedge clock) begin
      if (advance) begin
         if (q_last > MAXV_Q) begin
            out_quot_ff <= neg_ff[NB-1] ? MINV : MAXV;
         end else if (neg_ff[NB-1]) begin
            out_quot_ff <= W'(-q_last[W-1:0]);
         end else begin
            out_quot_ff <= q_last[W-1:0];
         end
         out_side_ff <= side_ff[NB-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= vld_ff[NB-1];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_quot  = out_quot_ff;
   assign out_side  = out_side_ff;
endmodule

// ===== rtl/chol3_checker.sv =====
// Port-level checker for the 3x3 Cholesky block, with its bind.
`timescale 1ns / 1ps
`include "cholesky_3x3_decompose_macros.svh"
module chol3_checker
   import chol3_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic signed [IO_W-1:0] rsp_u_00,
   input logic signed [IO_W-1:0] rsp_u_01,
   input logic signed [IO_W-1:0] rsp_u_02,
   input logic signed [IO_W-1:0] rsp_u_11,
   input logic signed [IO_W-1:0] rsp_u_12,
   input logic signed [IO_W-1:0] rsp_u_22,
   input logic                   rsp_success
);
   logic u_all_zero;
   logic diag_pos;

   assign u_all_zero = (rsp_u_00 == 0) && (rsp_u_01 == 0) && (rsp_u_02 == 0)
                       && (rsp_u_11 == 0) && (rsp_u_12 == 0) && (rsp_u_22 == 0);
   assign diag_pos   = (rsp_u_00 > 0) && (rsp_u_11 > 0) && (rsp_u_22 > 0);

   // Hold a stalled result
   `CHOL3_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
   // Accept input whenever the output slot is free
   `CHOL3_ASSERT_NOW(a_ready_free, clock, reset, !rsp_valid, req_ready, "input stalled with empty output")
   // A failed item carries all-zero entries
   `CHOL3_ASSERT_NOW(a_fail_zero, clock, reset, rsp_valid && !rsp_success, u_all_zero, "failed item has nonzero entries")
   // A good item has positive diagonal roots
   `CHOL3_ASSERT_NOW(a_diag_pos, clock, reset, rsp_valid && rsp_success, diag_pos, "diagonal root not positive")
endmodule

bind cholesky_3x3_decompose chol3_checker u_chol3_checker (.*);

// ===== verif/tb_cholesky_3x3_decompose.sv =====
// Self-checking testbench for the pipelined 3x3 Cholesky decomposition block.
`timescale 1ns / 1ps
module tb_cholesky_3x3_decompose;
   import chol3_pkg::*;

   localparam int FRAC      = 24;
   localparam int LATENCY   = 329;
   localparam int IDLE_MAX  = 20000;
   localparam int N_RANDOM  = 1600;
   localparam logic signed [IO_W-1:0] SMAX = {1'b0, {(IO_W-1){1'b1}}};
   localparam logic signed [IO_W-1:0] SMIN = {1'b1, {(IO_W-1){1'b0}}};
   localparam logic signed [IO_W-1:0] ONE  = 64'sd1 << FRAC;

   typedef struct {
      logic signed [IO_W-1:0] a00, a10, a11, a20, a21, a22;
   } matrix_type;

   typedef struct {
      logic signed [IO_W-1:0] u00, u01, u02, u11, u12, u22;
      logic                   ok;
   } factor_type;

   logic                   clock, reset;
   logic                   csr_wr_en;
   logic [TOL_W-1:0]       csr_wr_data;
   logic                   req_valid, req_ready;
   logic signed [IO_W-1:0] req_a_00, req_a_10, req_a_11, req_a_20, req_a_21, req_a_22;
   logic                   rsp_valid, rsp_ready;
   logic signed [IO_W-1:0] rsp_u_00, rsp_u_01, rsp_u_02, rsp_u_11, rsp_u_12, rsp_u_22;
   logic                   rsp_success;

   matrix_type       pending_mats[$];
   factor_type       expected_factors[$];
   logic [TOL_W-1:0] model_tol;
   bit               hold_req, no_idle, req_taken;
   int               req_gap, rsp_gap, idle_cycles, errors;

   cholesky_3x3_decompose uut (.*);

   // Generate the clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // --- fixed-point predictor ---
   function automatic logic [IO_W-1:0] magnitude(logic signed [IO_W-1:0] v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic signed [IO_W-1:0] clamp_mag(bit neg, logic [127:0] m);
      if (m > 128'(SMAX)) return neg ? SMIN : SMAX;
      return neg ? -$signed(m[IO_W-1:0]) : $signed(m[IO_W-1:0]);
   endfunction

   function automatic logic signed [IO_W-1:0] clamp_wide(logic signed [IO_W:0] s);
      if (s > $signed({1'b0, SMAX})) return SMAX;
      if (s < $signed({1'b1, SMIN})) return SMIN;
      return s[IO_W-1:0];
   endfunction

   function automatic logic signed [IO_W-1:0] q_mul(logic signed [IO_W-1:0] a,
                                                    logic signed [IO_W-1:0] b);
      logic [127:0] p;
      p = (128'(magnitude(a)) * 128'(magnitude(b))) >> FRAC;
      return clamp_mag((a < 0) != (b < 0), p);
   endfunction

   function automatic logic signed [IO_W-1:0] q_div(logic signed [IO_W-1:0] n,
                                                    logic signed [IO_W-1:0] d);
      logic [127:0] q;
      q = (128'(magnitude(n)) << FRAC) / 128'(d);
      return clamp_mag(n < 0, q);
   endfunction

   function automatic logic signed [IO_W-1:0] q_sqrt(logic signed [IO_W-1:0] p);
      logic [127:0] x, r, c;
      x = 128'(p) << FRAC;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         c = r | (128'd1 << b);
         if (c * c <= x) r = c;
      end
      return clamp_mag(1'b0, r);
   endfunction

   // Fold a shallow negative pivot, reject a deep negative or zero one
   function automatic bit pivot_sqrt(logic signed [IO_W-1:0] p, output logic signed [IO_W-1:0] root);
      root = '0;
      if (p < 0) begin
         if (magnitude(p) < IO_W'(model_tol)) p = -p;
         else return 1'b0;
      end
      root = q_sqrt(p);
      return root != 0;
   endfunction

   function automatic factor_type decompose(matrix_type m);
      factor_type f;
      logic signed [IO_W-1:0] l00, l10, l11, l20, l21, l22;
      bit ok;
      l00 = 0; l10 = 0; l11 = 0; l20 = 0; l21 = 0; l22 = 0;
      ok = pivot_sqrt(m.a00, l00);
      if (ok) begin
         l10 = q_div(m.a10, l00);
         ok = pivot_sqrt(clamp_wide(m.a11 - q_mul(l10, l10)), l11);
      end
      if (ok) begin
         l20 = q_div(m.a20, l00);
         l21 = q_div(clamp_wide(m.a21 - q_mul(l20, l10)), l11);
         ok = pivot_sqrt(clamp_wide(m.a22 - clamp_wide(q_mul(l20, l20) + q_mul(l21, l21))), l22);
      end
      f.ok = ok;
      f.u00 = ok ? l00 : '0;
      f.u01 = ok ? l10 : '0;
      f.u02 = ok ? l20 : '0;
      f.u11 = ok ? l11 : '0;
      f.u12 = ok ? l21 : '0;
      f.u22 = ok ? l22 : '0;
      return f;
   endfunction

   // --- stimulus helpers ---
   task automatic push_matrix(logic signed [IO_W-1:0] a00, a10, a11, a20, a21, a22);
      matrix_type m;
      m.a00 = a00; m.a10 = a10; m.a11 = a11; m.a20 = a20; m.a21 = a21; m.a22 = a22;
      pending_mats = {pending_mats, m};
   endtask

   function automatic logic signed [IO_W-1:0] rand_word();
      return {$urandom(), $urandom()};
   endfunction

   // Build A = L * L^T from a random lower factor, then sometimes nudge the last diagonal
   task automatic push_spd();
      logic signed [127:0] l[6], a[6];
      int scale;
      scale = $urandom_range(0, 14);
      for (int i = 0; i < 6; i++) begin
         l[i] = $signed(128'($urandom_range(0, (1 << 20) - 1))) << scale;
         if (i inside {1, 3, 4} && $urandom_range(0, 1)) l[i] = -l[i];
      end
      // l: 0=l00 1=l10 2=l11 3=l20 4=l21 5=l22
      a[0] = (l[0] * l[0]) >>> FRAC;
      a[1] = (l[1] * l[0]) >>> FRAC;
      a[2] = (l[1] * l[1] + l[2] * l[2]) >>> FRAC;
      a[3] = (l[3] * l[0]) >>> FRAC;
      a[4] = (l[3] * l[1] + l[4] * l[2]) >>> FRAC;
      a[5] = (l[3] * l[3] + l[4] * l[4] + l[5] * l[5]) >>> FRAC;
      if ($urandom_range(0, 3) == 0) a[5] = a[5] - (l[5] * l[5] >>> FRAC)
                                             + $signed(128'($urandom_range(0, 600))) - 300;
      push_matrix(IO_W'(a[0]), IO_W'(a[1]), IO_W'(a[2]),
                  IO_W'(a[3]), IO_W'(a[4]), IO_W'(a[5]));
   endtask

   task automatic push_random_batch(int count);
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0, 1: push_matrix(rand_word(), rand_word(), rand_word(),
                              rand_word(), rand_word(), rand_word());
            2: push_matrix(ONE, rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
            default: push_spd();
         endcase
      end
   endtask

   task automatic wait_drained();
      while (pending_mats.size() != 0 || req_valid || expected_factors.size() != 0)
         @(posedge clock);
   endtask

   // Write the tolerance register while the pipeline is empty
   task automatic write_tolerance(logic [TOL_W-1:0] value);
      wait_drained();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      model_tol = value;
   endtask

   // --- sequence ---
   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      model_tol = TOL_RESET;
      hold_req = 1'b0;
      no_idle = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: identity, zero, extremes, folded and rejected pivots
      push_matrix(ONE, 0, ONE, 0, 0, ONE);
      push_matrix(0, 0, 0, 0, 0, 0);
      push_matrix(SMAX, SMAX, SMAX, SMAX, SMAX, SMAX);
      push_matrix(SMIN, SMIN, SMIN, SMIN, SMIN, SMIN);
      push_matrix(SMAX, SMIN, SMAX, SMIN, SMAX, SMAX);
      push_matrix(-100, 0, ONE, 0, 0, ONE);
      push_matrix(-167, 5, ONE, 7, 3, ONE);
      push_matrix(-168, 0, ONE, 0, 0, ONE);
      push_matrix(-200, 0, ONE, 0, 0, ONE);
      push_matrix(ONE, 0, -50, 0, 0, ONE);
      push_matrix(ONE, 0, -300, 0, 0, ONE);
      push_matrix(ONE, 0, ONE, 0, 0, -10);
      push_matrix(ONE, 0, ONE, 0, 0, -1000);
      push_matrix(ONE, 0, ONE, 0, 0, 0);
      push_matrix(ONE, ONE, ONE, 0, 0, ONE);
      push_matrix(1, SMAX, SMAX, SMIN, SMAX, SMAX);
      push_matrix(1, 1, SMAX, -1, 0, SMAX);
      push_matrix(4 * ONE, 2 * ONE, 5 * ONE, -2 * ONE, ONE, 6 * ONE);
      push_matrix(SMAX, 0, 1, 0, 0, 1);
      push_matrix(-1, -1, -1, -1, -1, -1);
      push_random_batch(N_RANDOM / 4);

      write_tolerance('0);
      push_matrix(-1, 0, ONE, 0, 0, ONE);
      push_matrix(ONE, 0, ONE, 0, 0, -1);
      push_random_batch(N_RANDOM / 4);

      // Back-to-back transfers with no gaps on either side
      write_tolerance(16'hFFFF);
      no_idle = 1'b1;
      push_matrix(-65534, 0, ONE, 0, 0, ONE);
      push_matrix(-65535, 0, ONE, 0, 0, ONE);
      push_matrix(ONE, 0, -65534, 0, 0, -65535);
      push_random_batch(N_RANDOM / 4);
      wait_drained();
      no_idle = 1'b0;

      write_tolerance(TOL_W'($urandom()));
      push_random_batch(N_RANDOM / 8);
      // Let part of the batch go, hold the sender until the pipeline is empty, then resume
      while (pending_mats.size() > N_RANDOM / 16) @(posedge clock);
      hold_req = 1'b1;
      while (req_valid || expected_factors.size() != 0) @(posedge clock);
      hold_req = 1'b0;
      push_random_batch(N_RANDOM / 8);

      wait_drained();
      repeat (LATENCY + 50) @(posedge clock);
      if (errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(20, 60);
   endfunction

   // Drive request payload at the falling edge
   always @(negedge clock) begin
      matrix_type m;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else if (!req_valid || req_taken) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap   <= req_gap - 1;
         end else if (!hold_req && pending_mats.size() != 0) begin
            m = pending_mats.pop_front();
            req_valid <= 1'b1;
            req_a_00 <= m.a00; req_a_10 <= m.a10; req_a_11 <= m.a11;
            req_a_20 <= m.a20; req_a_21 <= m.a21; req_a_22 <= m.a22;
            req_gap <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Toggle result ready at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap   <= 0;
      end else if (rsp_gap > 0) begin
         rsp_ready <= 1'b0;
         rsp_gap   <= rsp_gap - 1;
      end else begin
         rsp_ready <= 1'b1;
         rsp_gap   <= pick_gap();
      end
   end

   initial begin
      req_valid = 1'b0; rsp_ready = 1'b0; req_taken = 1'b0;
      req_a_00 = '0; req_a_10 = '0; req_a_11 = '0;
      req_a_20 = '0; req_a_21 = '0; req_a_22 = '0;
      req_gap = 0; rsp_gap = 0; idle_cycles = 0; errors = 0;
   end

   task automatic check_field(string name, logic signed [IO_W-1:0] exp_v,
                              logic signed [IO_W-1:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         errors++;
      end
   endtask

   // Predict on request transfer, check on result transfer, watch for a hang
   always @(posedge clock) begin
      matrix_type m;
      factor_type f;
      bit moved;
      moved = 1'b0;
      req_taken <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            m.a00 = req_a_00; m.a10 = req_a_10; m.a11 = req_a_11;
            m.a20 = req_a_20; m.a21 = req_a_21; m.a22 = req_a_22;
            f = decompose(m);
            expected_factors = {expected_factors, f};
            moved = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            moved = 1'b1;
            if (expected_factors.size() == 0) begin
               $error("result transfer with no matrix outstanding");
               errors++;
            end else begin
               f = expected_factors.pop_front();
               check_field("u_00", f.u00, rsp_u_00);
               check_field("u_01", f.u01, rsp_u_01);
               check_field("u_02", f.u02, rsp_u_02);
               check_field("u_11", f.u11, rsp_u_11);
               check_field("u_12", f.u12, rsp_u_12);
               check_field("u_22", f.u22, rsp_u_22);
               if (rsp_success !== f.ok) begin
                  $error("success: expected %0d, got %0d", f.ok, rsp_success);
                  errors++;
               end
            end
         end
         idle_cycles <= moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_MAX) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/chol3_pkg.sv
rtl/chol3_sqrt.sv
rtl/chol3_div.sv
rtl/cholesky_3x3_decompose.sv
rtl/chol3_checker.sv
verif/tb_cholesky_3x3_decompose.sv
